// File: hdl/pbftx_pkg.sv
// Package for the printer byte filter with tab expansion.
// Holds the character codes, register indexes and the command type passed
// from the front to the back. No dependencies.
`default_nettype none

package pbftx_pkg;

    // Character codes
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd127;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINT_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT   = 1'd1;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd200;

    // Repeat count holds results minus one; a tab stop of up to 16 fits
    localparam int unsigned COUNT_W = 4;

    // Command queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;

    // One classified transaction ready for the back end
    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               refused;
        logic               closed;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/pbftx_in_if.sv
// Input channel of the printer byte filter: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface pbftx_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/pbftx_out_if.sv
// Output channel of the printer byte filter: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface pbftx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       refused;
    logic       closed;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output refused,
                    output closed, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input refused,
                    input closed, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/pbftx_front.sv
// Front end: configuration registers, connection/column/idle state and
// classification of each input transaction into a command. Uses pbftx_pkg.
`default_nettype none

module pbftx_front #(
    parameter int unsigned TAB_WIDTH = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pbftx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pbftx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_action,
    input  wire logic [7:0]                        in_data_byte,
    output logic                                   cmd_valid,
    input  wire logic                              cmd_ready,
    output pbftx_pkg::cmd_t                        cmd
);

    localparam int unsigned COL_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(TAB_WIDTH - 1);
    localparam logic [pbftx_pkg::COUNT_W-1:0] CNT_MAX =
        pbftx_pkg::COUNT_W'(TAB_WIDTH - 1);

    logic        print_enable_reg;
    logic [15:0] idle_limit_reg;
    logic        connected_reg, connected_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic        pending_reg, pending_next;
    logic [15:0] idle_reg, idle_next;

    logic             accept;
    logic [COL_W-1:0] col_eff;
    logic [COL_W-1:0] col_inc;
    logic             pending_eff;
    logic [15:0]      idle_inc;
    logic             printable;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            print_enable_reg <= 1'b0;
            idle_limit_reg   <= pbftx_pkg::IDLE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbftx_pkg::REG_PRINT_ENABLE: print_enable_reg <= cfg_data[0];
                pbftx_pkg::REG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Classification and next state
    always_comb
    begin
        col_eff     = connected_reg ? column_reg : '0;
        pending_eff = connected_reg ? pending_reg : 1'b0;
        col_inc     = (col_eff == COL_MAX) ? '0 : col_eff + 1'b1;
        idle_inc    = idle_reg + 16'd1;
        printable   = (in_data_byte >= pbftx_pkg::PRINT_LO) &&
                      (in_data_byte < pbftx_pkg::PRINT_HI);

        connected_next = connected_reg;
        column_next    = column_reg;
        pending_next   = pending_reg;
        idle_next      = idle_reg;

        cmd            = '0;

        if (in_action)
        begin
            // idle check tick
            if (pending_reg)
            begin
                pending_next = 1'b0;
                idle_next    = '0;
            end
            else if (idle_inc >= idle_limit_reg)
            begin
                connected_next = 1'b0;
                pending_next   = 1'b0;
                idle_next      = '0;
                cmd.closed     = 1'b1;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else if (!print_enable_reg)
        begin
            cmd.refused = 1'b1;
        end
        else
        begin
            // a byte while disconnected opens the connection first
            connected_next = 1'b1;
            column_next    = col_eff;
            pending_next   = pending_eff;
            if (in_data_byte == pbftx_pkg::BYTE_TAB)
            begin
                cmd.out_byte   = pbftx_pkg::BYTE_SPACE;
                cmd.byte_valid = 1'b1;
                cmd.count      = CNT_MAX - pbftx_pkg::COUNT_W'(col_eff);
                column_next    = '0;
                pending_next   = 1'b1;
            end
            else if (in_data_byte == pbftx_pkg::BYTE_CR)
            begin
                cmd.out_byte   = in_data_byte;
                cmd.byte_valid = 1'b1;
                column_next    = '0;
                pending_next   = 1'b1;
            end
            else if (in_data_byte == pbftx_pkg::BYTE_LF)
            begin
                cmd.out_byte   = in_data_byte;
                cmd.byte_valid = 1'b1;
                pending_next   = 1'b1;
            end
            else if (printable)
            begin
                cmd.out_byte   = in_data_byte;
                cmd.byte_valid = 1'b1;
                column_next    = col_inc;
                pending_next   = 1'b1;
            end
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            column_reg    <= '0;
            pending_reg   <= 1'b0;
            idle_reg      <= '0;
        end
        else if (accept)
        begin
            connected_reg <= connected_next;
            column_reg    <= column_next;
            pending_reg   <= pending_next;
            idle_reg      <= idle_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pbftx_queue.sv
// Short command queue between front and back ends.
// Uses pbftx_pkg for the command type and depth.
`default_nettype none

module pbftx_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire pbftx_pkg::cmd_t  wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output pbftx_pkg::cmd_t       rd_data
);

    localparam int unsigned PTR_W = pbftx_pkg::QUEUE_PTR_W;

    pbftx_pkg::cmd_t  mem_reg [pbftx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             push, pop;

    assign wr_ready = (fill_reg != (PTR_W+1)'(pbftx_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pbftx_back.sv
// Back end: expands each command into its results, one per cycle while the
// output is not stalled, through an output register. Uses pbftx_pkg and pbftx_out_if.
`default_nettype none

module pbftx_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire pbftx_pkg::cmd_t cmd,
    pbftx_out_if.source          out_ch
);

    pbftx_pkg::cmd_t                cur_reg;
    logic                           cur_valid_reg;
    logic [pbftx_pkg::COUNT_W-1:0]  rem_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg, refused_reg, closed_reg, last_reg;

    logic out_free, emit, rem_zero, take;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit      = cur_valid_reg && out_free;
    assign rem_zero  = (rem_reg == '0);
    assign cmd_ready = !cur_valid_reg || (emit && rem_zero);
    assign take      = cmd_valid && cmd_ready;

    // Current command and repeat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else if (take)
        begin
            cur_valid_reg <= 1'b1;
            rem_reg       <= cmd.count;
        end
        else if (emit)
        begin
            if (rem_zero)
                cur_valid_reg <= 1'b0;
            else
                rem_reg <= rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= cmd;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= cur_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= cur_reg.out_byte;
            byte_valid_reg <= cur_reg.byte_valid;
            refused_reg    <= cur_reg.refused;
            closed_reg     <= cur_reg.closed;
            last_reg       <= rem_zero;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.byte_valid = byte_valid_reg;
    assign out_ch.refused    = refused_reg;
    assign out_ch.closed     = closed_reg;
    assign out_ch.last       = last_reg;

endmodule

`default_nettype wire

// File: hdl/printer_byte_filter_tab_expander_core.sv
// Printer byte filter with tab expansion. The front end takes one input
// transaction per cycle while its four-entry command queue has room, updating
// the connection, column and idle state at once; the back end turns each
// command into results at one per cycle, while the output is not stalled,
// through an output register. A tab gives TAB_WIDTH minus the current column
// results, any other transaction gives one, so an item yields 1 to TAB_WIDTH
// results and that number sets the sustained rate. Configuration is written by
// index: 0 is print_enable, 1 is idle_limit (reset 200).
// Depends on pbftx_pkg, pbftx_in_if, pbftx_out_if, pbftx_front,
// pbftx_queue and pbftx_back.
`default_nettype none

module printer_byte_filter_tab_expander_core #(
    parameter int unsigned TAB_WIDTH = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pbftx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pbftx_pkg::CFG_DATA_W-1:0]  cfg_data,
    pbftx_in_if.sink                               in_ch,
    pbftx_out_if.source                            out_ch
);

    logic            f_valid, f_ready;
    pbftx_pkg::cmd_t f_cmd;
    logic            q_valid, q_ready;
    pbftx_pkg::cmd_t q_cmd;

    // Front end: classification and state
    pbftx_front #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_action    (in_ch.action),
        .in_data_byte (in_ch.data_byte),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd          (f_cmd)
    );

    // Command queue
    pbftx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    // Back end: result expansion
    pbftx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// File: verif/tb_printer_byte_filter_tab_expander_core.sv
// Self-checking testbench for printer_byte_filter_tab_expander_core.
// Depends on pbftx_pkg, pbftx_in_if, pbftx_out_if and the core; predicts the
// filtered, tab-expanded output and the idle-close reports for every transaction.
`timescale 1ns / 1ps

module tb_printer_byte_filter_tab_expander_core;

    localparam int TAB_W = 8;

    // Input item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       refused;
        logic       closed;
        logic       last;
    } printer_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [pbftx_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pbftx_pkg::CFG_DATA_W-1:0]  cfg_data;

    pbftx_in_if  in_ch ();
    pbftx_out_if out_ch ();

    printer_result_t expected_results[$];
    int              mismatch_count;
    int              src_idle_pct;
    int              snk_idle_pct;

    // Predictor copy of configuration and state
    logic        mdl_print_enable;
    logic [15:0] mdl_idle_limit;
    logic        mdl_connected;
    int          mdl_column;
    logic        mdl_bytes_pending;
    logic [15:0] mdl_idle_ticks;

    printer_byte_filter_tab_expander_core #(
        .TAB_WIDTH (TAB_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("printer_byte_filter_tab_expander_core test failed");
        $finish;
    end

    // Work out the results of one accepted transaction
    task automatic predict_printer(input logic act, input logic [7:0] b);
        printer_result_t r;
        int              n;
        r = '0;
        r.last = 1'b1;
        if (act == ACT_TICK)
        begin
            if (mdl_bytes_pending)
            begin
                mdl_bytes_pending = 1'b0;
                mdl_idle_ticks    = '0;
            end
            else
            begin
                mdl_idle_ticks = mdl_idle_ticks + 16'd1;
                if (mdl_idle_ticks >= mdl_idle_limit)
                begin
                    mdl_connected     = 1'b0;
                    mdl_bytes_pending = 1'b0;
                    mdl_idle_ticks    = '0;
                    r.closed          = 1'b1;
                end
            end
            expected_results.push_back(r);
        end
        else if (!mdl_print_enable)
        begin
            r.refused = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            // a byte while disconnected opens the connection first
            if (!mdl_connected)
            begin
                mdl_connected     = 1'b1;
                mdl_bytes_pending = 1'b0;
                mdl_column        = 0;
            end
            if (b == pbftx_pkg::BYTE_TAB)
            begin
                n = TAB_W - mdl_column;
                for (int i = 0; i < n; i++)
                begin
                    r.out_byte   = pbftx_pkg::BYTE_SPACE;
                    r.byte_valid = 1'b1;
                    r.last       = (i == n - 1);
                    expected_results.push_back(r);
                    mdl_column = (mdl_column + 1) % TAB_W;
                end
                mdl_bytes_pending = 1'b1;
            end
            else if (b == pbftx_pkg::BYTE_CR || b == pbftx_pkg::BYTE_LF ||
                     (b >= pbftx_pkg::PRINT_LO && b < pbftx_pkg::PRINT_HI))
            begin
                if (b == pbftx_pkg::BYTE_CR)
                    mdl_column = 0;
                else if (b != pbftx_pkg::BYTE_LF)
                    mdl_column = (mdl_column + 1) % TAB_W;
                mdl_bytes_pending = 1'b1;
                r.out_byte        = b;
                r.byte_valid      = 1'b1;
                expected_results.push_back(r);
            end
            else
                expected_results.push_back(r);  // dropped byte
        end
    endtask

    // Send one transaction; valid is left high so the next one can follow at once
    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_printer(act, b);
    endtask

    // Stop sending and wait until every outstanding result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Register write; only called with the block idle
    task automatic write_reg(input logic [pbftx_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == pbftx_pkg::REG_PRINT_ENABLE)
            mdl_print_enable = val[0];
        else
            mdl_idle_limit = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic note_mismatch(input printer_result_t exp_r, input printer_result_t got_r,
                                 input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (orphan)
                $display("%0t: unexpected result byte=%h valid=%b refused=%b closed=%b",
                         $realtime, got_r.out_byte, got_r.byte_valid, got_r.refused,
                         got_r.closed, " last=%b", got_r.last);
            else
            begin
                $display("%0t: mismatch exp byte=%h valid=%b refused=%b closed=%b last=%b",
                         $realtime, exp_r.out_byte, exp_r.byte_valid, exp_r.refused,
                         exp_r.closed, exp_r.last);
                $display("%0t:          got byte=%h valid=%b refused=%b closed=%b last=%b",
                         $realtime, got_r.out_byte, got_r.byte_valid, got_r.refused,
                         got_r.closed, got_r.last);
            end
        end
    endtask

    // Result checker and receiver stall
    always @(posedge clk)
    begin
        printer_result_t got_r;
        printer_result_t exp_r;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got_r.out_byte   = out_ch.out_byte;
            got_r.byte_valid = out_ch.byte_valid;
            got_r.refused    = out_ch.refused;
            got_r.closed     = out_ch.closed;
            got_r.last       = out_ch.last;
            if (expected_results.size() == 0)
                note_mismatch('0, got_r, 1'b1);
            else
            begin
                exp_r = expected_results.pop_front();
                if (got_r !== exp_r)
                    note_mismatch(exp_r, got_r, 1'b0);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Bytes are refused while printing is off at reset; ticks still count
    task automatic test_refused_when_disabled();
        send_item(ACT_BYTE, 8'h41);
        send_item(ACT_BYTE, 8'hff);
        send_item(ACT_TICK, 8'h00);
        drain_results();
    endtask

    // Filtering, tab expansion and column tracking
    task automatic test_byte_filter();
        write_reg(pbftx_pkg::REG_PRINT_ENABLE, 16'd1);
        send_item(ACT_BYTE, 8'h00);       // dropped, but connects and clears the column
        send_item(ACT_BYTE, pbftx_pkg::BYTE_TAB);    // full tab stop
        send_item(ACT_BYTE, pbftx_pkg::PRINT_LO);
        send_item(ACT_BYTE, 8'h7e);
        send_item(ACT_BYTE, pbftx_pkg::PRINT_HI);    // DEL is dropped
        send_item(ACT_BYTE, 8'h1f);
        send_item(ACT_BYTE, 8'hff);
        send_item(ACT_BYTE, 8'h80);
        send_item(ACT_BYTE, pbftx_pkg::BYTE_LF);     // no column advance
        send_item(ACT_BYTE, pbftx_pkg::BYTE_TAB);    // partial tab
        send_item(ACT_BYTE, pbftx_pkg::BYTE_CR);
        send_item(ACT_BYTE, 8'h41);
        drain_results();
    endtask

    // Idle counting, closing, repeated close while disconnected, limit changes
    task automatic test_idle_close();
        write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'd1);
        send_item(ACT_TICK, 8'h00);       // bytes since last tick: clears the count
        send_item(ACT_TICK, 8'h00);       // closes
        send_item(ACT_TICK, 8'h00);       // closes again while disconnected
        drain_results();
        write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'd0);
        send_item(ACT_TICK, 8'h00);
        drain_results();
        write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'd3);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        drain_results();
        // limit lowered below the running count
        write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'd1);
        send_item(ACT_TICK, 8'h00);
        drain_results();
        write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'hffff);
        send_item(ACT_TICK, 8'h00);
        drain_results();
    endtask

    // Random text with bursts of idle ticks; settings change between batches
    task automatic test_random_traffic(input int n_items);
        int sent;
        int kind;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            write_reg(pbftx_pkg::REG_PRINT_ENABLE, {15'd0, ($urandom_range(9) != 0)});
            case ($urandom_range(5))
                0: write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'd1);
                1: write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'hffff);
                default: write_reg(pbftx_pkg::REG_IDLE_LIMIT, 16'($urandom_range(2, 6)));
            endcase
            for (int i = 0; i < 19 && sent < n_items; i++)
            begin
                kind = $urandom_range(99);
                if (kind < 40)
                    send_item(ACT_BYTE, 8'($urandom_range(32, 126)));
                else if (kind < 55)
                    send_item(ACT_BYTE, pbftx_pkg::BYTE_TAB);
                else if (kind < 65)
                    send_item(ACT_BYTE, $urandom_range(1) ? pbftx_pkg::BYTE_CR
                                                          : pbftx_pkg::BYTE_LF);
                else if (kind < 75)
                    send_item(ACT_BYTE, 8'($urandom_range(255)));
                else
                begin
                    burst = $urandom_range(1, 5);
                    for (int k = 0; k < burst; k++)
                        send_item(ACT_TICK, 8'($urandom_range(255)));
                    sent += burst - 1;
                end
                sent++;
            end
            drain_results();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_BYTE;
        in_ch.data_byte <= 8'h00;
        mismatch_count    = 0;
        src_idle_pct      = 16;
        snk_idle_pct      = 60;
        mdl_print_enable  = 1'b0;
        mdl_idle_limit    = pbftx_pkg::IDLE_LIMIT_RESET;
        mdl_connected     = 1'b0;
        mdl_column        = 0;
        mdl_bytes_pending = 1'b0;
        mdl_idle_ticks    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_refused_when_disabled();
        test_byte_filter();
        test_idle_close();

        test_random_traffic(50);
        src_idle_pct = 60;
        snk_idle_pct = 16;
        test_random_traffic(50);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(50);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("printer_byte_filter_tab_expander_core test passed");
        else
            $display("printer_byte_filter_tab_expander_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/pbftx_pkg.sv
hdl/pbftx_in_if.sv
hdl/pbftx_out_if.sv
hdl/pbftx_front.sv
hdl/pbftx_queue.sv
hdl/pbftx_back.sv
hdl/printer_byte_filter_tab_expander_core.sv
verif/tb_printer_byte_filter_tab_expander_core.sv
